// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cpualu_pkg.sv =====
package cpualu_pkg;

    localparam int unsigned MODE_W  = 6;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BIDX_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        OP_ADD   = 6'd0,
        OP_ADC   = 6'd1,
        OP_SUB   = 6'd2,
        OP_SBC   = 6'd3,
        OP_AND   = 6'd4,
        OP_XOR   = 6'd5,
        OP_OR    = 6'd6,
        OP_CP    = 6'd7,
        OP_INC8  = 6'd8,
        OP_DEC8  = 6'd9,
        OP_DAA   = 6'd10,
        OP_CPL   = 6'd11,
        OP_SCF   = 6'd12,
        OP_CCF   = 6'd13,
        OP_RLCA  = 6'd14,
        OP_RRCA  = 6'd15,
        OP_RLA   = 6'd16,
        OP_RRA   = 6'd17,
        OP_RLC   = 6'd18,
        OP_RRC   = 6'd19,
        OP_RL    = 6'd20,
        OP_RR    = 6'd21,
        OP_SLA   = 6'd22,
        OP_SRA   = 6'd23,
        OP_SWAP  = 6'd24,
        OP_SRL   = 6'd25,
        OP_BIT   = 6'd26,
        OP_RES   = 6'd27,
        OP_SET   = 6'd28,
        OP_ADD16 = 6'd29,
        OP_ADDSP = 6'd30,
        OP_INC16 = 6'd31,
        OP_DEC16 = 6'd32
    } alu_op_t;

    // highest defined code; anything above is a no-op
    localparam logic [MODE_W-1:0] OP_LAST = OP_DEC16;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [BIDX_W-1:0] bit_index;
        logic              flag_z;
        logic              flag_n;
        logic              flag_h;
        logic              flag_c;
    } alu_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic              write_back;
        logic              flag_z;
        logic              flag_n;
        logic              flag_h;
        logic              flag_c;
    } alu_out_t;

    localparam int unsigned IN_W  = $bits(alu_in_t);
    localparam int unsigned OUT_W = $bits(alu_out_t);

    // DAA correction constants
    localparam logic [BYTE_W-1:0] DAA_LO  = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_HI  = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_MAX = 8'h99;

endpackage

// ===== rtl/core/cpu_alu_with_flags_top.sv =====
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle while m_tready is high; the ALU is one combinational pass between the two.
// m_tready low holds the result register; an empty operand register still takes one
// more item, after which s_tready stays low until the held result is taken.
// Reset: aresetn, synchronous, active low; clears both valid bits, data is not reset.
module cpu_alu_with_flags_top
    import cpualu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] operand_a, [31:16] operand_b, [34:32] bit_index,
    // [35] flag_z_in, [36] flag_n_in, [37] flag_h_in, [38] flag_c_in, [39] zero
    input  logic [39:0] s_tdata,
    // [5:0] mode
    input  logic [5:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] result_value, [16] write_back, [17] flag_z_out,
    // [18] flag_n_out, [19] flag_h_out, [20] flag_c_out, [23:21] zero
    output logic [23:0] m_tdata
);

`include "assert_macros.svh"

    alu_in_t  in_item;
    alu_in_t  ex_item;
    alu_out_t ex_result;
    alu_out_t out_item;
    logic     ex_valid;
    logic     ex_ready;
    logic     s_fire;    // item accepted on the input side
    logic     ex_undef;  // undefined code moving into the result register
    logic     m_stall;   // result waiting on the receiver

    // unpack the bus into the operand record
    assign in_item.mode      = s_tuser;
    assign in_item.operand_a = s_tdata[15:0];
    assign in_item.operand_b = s_tdata[31:16];
    assign in_item.bit_index = s_tdata[34:32];
    assign in_item.flag_z    = s_tdata[35];
    assign in_item.flag_n    = s_tdata[36];
    assign in_item.flag_h    = s_tdata[37];
    assign in_item.flag_c    = s_tdata[38];

    // operand register
    cpualu_stage #(
        .Width (IN_W)
    ) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (ex_valid),
        .out_ready (ex_ready),
        .out_data  (ex_item)
    );

    // single-pass ALU and flag logic
    cpualu_exec u_exec (
        .op_in  (ex_item),
        .op_out (ex_result)
    );

    // result register
    cpualu_stage #(
        .Width (OUT_W)
    ) u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ex_valid),
        .in_ready  (ex_ready),
        .in_data   (ex_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign m_tdata = {3'b000, out_item.flag_c, out_item.flag_h, out_item.flag_n,
                      out_item.flag_z, out_item.write_back, out_item.result_value};

    assign s_fire   = s_tvalid && s_tready;
    assign ex_undef = ex_valid && ex_ready && (ex_item.mode > OP_LAST);
    assign m_stall  = m_tvalid && !m_tready;

    // no bubble: an empty result register never blocks the input side
    `ASSERT_CLK(a_no_stall_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled")

    // an accepted item always lands in the operand register
    `ASSERT_CLK(a_accept_loads, aclk, aresetn, s_fire |=> ex_valid, "accepted item lost")

    // undefined codes produce a zero, non-written result
    `ASSERT_CLK(a_unknown_op, aclk, aresetn, ex_undef |=> (m_tdata[16:0] == '0), "no-op wrote")

    // a held result must not change under the operand stage
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_stall |=> $stable({m_tvalid, m_tdata}), "item changed")

endmodule

// ===== rtl/core/cpualu_stage.sv =====
module cpualu_stage
    import cpualu_pkg::*;
#(
    parameter int unsigned Width = IN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [Width-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Width-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [Width-1:0] data_reg;

    // load whenever the slot is empty or drains this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/cpualu_exec.sv =====
module cpualu_exec
    import cpualu_pkg::*;
(
    input  alu_in_t  op_in,
    output alu_out_t op_out
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [WORD_W-1:0] a16;
    logic [WORD_W-1:0] b16;
    logic              cin_add;
    logic              cin_sub;
    logic [BYTE_W:0]   add9;
    logic [4:0]        add_h;
    logic [BYTE_W:0]   sub9;
    logic [4:0]        sub_h;
    logic [BYTE_W-1:0] daa_adj;
    logic              daa_c;
    logic [BYTE_W-1:0] daa_r;
    logic [BYTE_W-1:0] bit_mask;
    logic [WORD_W:0]   add17;
    logic [12:0]       add13;
    logic [WORD_W-1:0] sp_sum;
    logic [4:0]        sp_h;
    logic [BYTE_W:0]   sp_c;
    logic [BYTE_W-1:0] r8;

    assign a   = op_in.operand_a[BYTE_W-1:0];
    assign b   = op_in.operand_b[BYTE_W-1:0];
    assign a16 = op_in.operand_a;
    assign b16 = op_in.operand_b;

    assign cin_add = (op_in.mode == OP_ADC) && op_in.flag_c;
    assign cin_sub = (op_in.mode == OP_SBC) && op_in.flag_c;

    assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
    assign add_h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
    // borrow shows as the top bit of the widened difference
    assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
    assign sub_h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};

    always_comb begin
        daa_adj = '0;
        daa_c   = 1'b0;
        if (op_in.flag_h || (!op_in.flag_n && (a[3:0] > 4'd9))) begin
            daa_adj = DAA_LO;
        end
        if (op_in.flag_c || (!op_in.flag_n && (a > DAA_MAX))) begin
            daa_adj = daa_adj | DAA_HI;
            daa_c   = 1'b1;
        end
        daa_r = op_in.flag_n ? (a - daa_adj) : (a + daa_adj);
    end

    assign bit_mask = 8'(1) << op_in.bit_index;

    assign add17  = {1'b0, a16} + {1'b0, b16};
    assign add13  = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
    assign sp_sum = a16 + {{BYTE_W{b[BYTE_W-1]}}, b};
    assign sp_h   = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
    assign sp_c   = {1'b0, a16[BYTE_W-1:0]} + {1'b0, b};

    always_comb begin
        op_out.result_value = '0;
        op_out.write_back   = 1'b1;
        op_out.flag_z       = op_in.flag_z;
        op_out.flag_n       = op_in.flag_n;
        op_out.flag_h       = op_in.flag_h;
        op_out.flag_c       = op_in.flag_c;
        r8                  = '0;
        case (op_in.mode)
            OP_ADD, OP_ADC: begin
                r8            = add9[BYTE_W-1:0];
                op_out.flag_n = 1'b0;
                op_out.flag_h = add_h[4];
                op_out.flag_c = add9[BYTE_W];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                r8                = sub9[BYTE_W-1:0];
                op_out.flag_n     = 1'b1;
                op_out.flag_h     = sub_h[4];
                op_out.flag_c     = sub9[BYTE_W];
                op_out.write_back = (op_in.mode != OP_CP);
            end
            OP_AND: begin
                r8            = a & b;
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b1;
                op_out.flag_c = 1'b0;
            end
            OP_XOR: begin
                r8            = a ^ b;
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = 1'b0;
            end
            OP_OR: begin
                r8            = a | b;
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = 1'b0;
            end
            OP_INC8: begin
                r8            = a + 8'd1;
                op_out.flag_n = 1'b0;
                op_out.flag_h = (a[3:0] == 4'hF);
            end
            OP_DEC8: begin
                r8            = a - 8'd1;
                op_out.flag_n = 1'b1;
                op_out.flag_h = (a[3:0] == 4'h0);
            end
            OP_DAA: begin
                r8            = daa_r;
                op_out.flag_h = 1'b0;
                op_out.flag_c = daa_c;
            end
            OP_CPL: begin
                r8            = ~a;
                op_out.flag_n = 1'b1;
                op_out.flag_h = 1'b1;
            end
            OP_SCF, OP_CCF: begin
                r8                = a;
                op_out.write_back = 1'b0;
                op_out.flag_n     = 1'b0;
                op_out.flag_h     = 1'b0;
                op_out.flag_c     = (op_in.mode == OP_SCF) ? 1'b1 : !op_in.flag_c;
            end
            OP_RLCA, OP_RLC: begin
                r8            = {a[6:0], a[7]};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = a[7];
            end
            OP_RRCA, OP_RRC: begin
                r8            = {a[0], a[7:1]};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = a[0];
            end
            OP_RLA, OP_RL: begin
                r8            = {a[6:0], op_in.flag_c};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = a[7];
            end
            OP_RRA, OP_RR: begin
                r8            = {op_in.flag_c, a[7:1]};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = a[0];
            end
            OP_SLA: begin
                r8            = {a[6:0], 1'b0};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = a[7];
            end
            OP_SRA: begin
                r8            = {a[7], a[7:1]};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = a[0];
            end
            OP_SWAP: begin
                r8            = {a[3:0], a[7:4]};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = 1'b0;
            end
            OP_SRL: begin
                r8            = {1'b0, a[7:1]};
                op_out.flag_n = 1'b0;
                op_out.flag_h = 1'b0;
                op_out.flag_c = a[0];
            end
            OP_BIT: begin
                r8                = a;
                op_out.write_back = 1'b0;
                op_out.flag_n     = 1'b0;
                op_out.flag_h     = 1'b1;
            end
            OP_RES: r8 = a & ~bit_mask;
            OP_SET: r8 = a | bit_mask;
            default: r8 = '0;
        endcase

        // Z from the 8-bit result for most ops; RLCA/RRCA/RLA/RRA clear it, BIT takes it from the tested bit
        case (op_in.mode)
            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP, OP_AND, OP_XOR, OP_OR,
            OP_INC8, OP_DEC8, OP_DAA, OP_RLC, OP_RRC, OP_RL, OP_RR,
            OP_SLA, OP_SRA, OP_SWAP, OP_SRL: op_out.flag_z = (r8 == '0);
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: op_out.flag_z = 1'b0;
            OP_BIT: op_out.flag_z = !a[op_in.bit_index];
            default: op_out.flag_z = op_out.flag_z;
        endcase

        op_out.result_value = {{(WORD_W-BYTE_W){1'b0}}, r8};

        // 16-bit group and undefined codes
        case (op_in.mode)
            OP_ADD16: begin
                op_out.result_value = add17[WORD_W-1:0];
                op_out.flag_n       = 1'b0;
                op_out.flag_h       = add13[12];
                op_out.flag_c       = add17[WORD_W];
            end
            OP_ADDSP: begin
                op_out.result_value = sp_sum;
                op_out.flag_z       = 1'b0;
                op_out.flag_n       = 1'b0;
                op_out.flag_h       = sp_h[4];
                op_out.flag_c       = sp_c[BYTE_W];
            end
            OP_INC16: op_out.result_value = a16 + 16'd1;
            OP_DEC16: op_out.result_value = a16 - 16'd1;
            default: begin
                if (op_in.mode > OP_LAST) begin
                    op_out.result_value = '0;
                    op_out.write_back   = 1'b0;
                end
            end
        endcase
    end

endmodule
